@@ src/spbd_pkg.sv @@
// ----------------------------------------------------------------------------
// spbd_pkg: shared types, constants and table builder
// Frame and coefficient types, saturation, and the tanh table entry function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spbd_pkg;

  localparam int SampleBits    = 24;
  localparam int CoefBits      = 26;
  localparam int CoefFracBits  = 22;
  localparam int DriveBits     = 16;
  localparam int DriveFrac     = 14;
  localparam int RecipFrac     = 15;
  localparam int Channels      = 2;
  localparam int TanhDepth     = 1024;
  localparam int TabAddrBits   = $clog2(TanhDepth + 1);
  // table position fraction: magnitude covers 0..4 in Q.23, so 2 extra bits
  localparam int TanhFracBits  = SampleBits + 1;
  localparam int DrivenBits    = SampleBits + 2;
  localparam int CfgIndexBits  = 3;
  localparam int TdataBits     = Channels * SampleBits;
  localparam int QueueDepth    = 2;

  localparam int ExpTerms      = 30;
  localparam int ExpSquarings  = 4;
  localparam int NdShift       = 30;

  localparam logic [DriveBits-1:0]  DriveOne        = 16'd16384;
  localparam logic [DriveBits-1:0]  DriveGainReset  = 16'd16384;
  localparam logic [DriveBits-1:0]  DriveRecipReset = 16'd32768;
  localparam logic [63:0]           Q62One          = 64'd1 << 62;
  localparam logic [63:0]           TanhStep        = (64'd1 << 61) / TanhDepth;
  localparam logic [SampleBits-1:0] SampleMaxU      = {1'b0, {(SampleBits - 1){1'b1}}};
  localparam logic signed [31:0]    SatHi           = 32'(SampleMaxU);
  localparam logic signed [31:0]    SatLo           = -SatHi - 32'sd1;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [CoefBits-1:0]   coef_t;

  localparam coef_t CoefB0Reset = 26'sd4194304;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_GAIN  = 3'd5,
    REG_RECIP = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } biquad_coefs_t;

  typedef struct packed {
    logic [DriveBits-1:0] gain;
    logic [DriveBits-1:0] recip;
  } drive_cfg_t;

  // x[0] is left
  typedef struct packed {
    logic                     last;
    sample_t [Channels-1:0]   x;
  } frame_t;

  function automatic sample_t sat_sample(input logic signed [31:0] v);
    sample_t r;
    if (v > SatHi) begin
      r = SatHi[SampleBits-1:0];
    end else if (v < SatLo) begin
      r = SatLo[SampleBits-1:0];
    end else begin
      r = v[SampleBits-1:0];
    end
    return r;
  endfunction

  // Q.62 product, truncated; evaluated at elaboration only
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(4*idx/TanhDepth) in Q1.23 via e^-z series, z = 8*idx/TanhDepth
  function automatic logic [SampleBits-1:0] tanh_entry(input int idx);
    logic [63:0] w;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] t;
    w    = 64'(idx) * TanhStep;
    term = Q62One;
    e    = Q62One;
    for (int k = 1; k <= ExpTerms; k++) begin
      term = udiv64(mul_q62(term, w), 64'(k));
      if (k[0]) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (int k = 0; k < ExpSquarings; k++) begin
      e = mul_q62(e, e);
    end
    n = (Q62One - e) >> NdShift;
    d = (Q62One + e) >> NdShift;
    t = udiv64((n << (SampleBits - 1)) + (d >> 1), d);
    if (t > 64'(SampleMaxU)) begin
      t = 64'(SampleMaxU);
    end
    return t[SampleBits-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/stereo_peaking_biquad_with_drive.sv @@
// ----------------------------------------------------------------------------
// stereo_peaking_biquad_with_drive: stereo tanh drive and peaking biquad
// The per-lane tap multiplier of the biquad back end takes each frame through
// pop, five taps, accumulate and commit before it pops the next; the drive front
// also holds one frame at a time, and the queue lets it work ahead of the back end.
// Reset: history zeroed, registers at defaults, queue empty; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_peaking_biquad_with_drive #(
  parameter int unsigned QueueDepth = spbd_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [spbd_pkg::TdataBits-1:0]    s_axis_tdata,   // left_sample, right_sample
  input  logic                              s_axis_tlast,   // last_frame
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [spbd_pkg::TdataBits-1:0]    m_axis_tdata,   // left_out, right_out
  output logic                              m_axis_tlast,   // last_frame_out
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spbd_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [spbd_pkg::CoefBits-1:0]     cfg_data_i
);

  localparam int SampleBits = spbd_pkg::SampleBits;

  spbd_pkg::biquad_coefs_t coefs_q;
  spbd_pkg::drive_cfg_t    drive_q;
  spbd_pkg::frame_t        in_frame;
  spbd_pkg::frame_t        q_in_frame;
  spbd_pkg::frame_t        q_out_frame;
  spbd_pkg::frame_t        out_frame;
  logic                    q_push_valid;
  logic                    q_push_ready;
  logic                    q_pop_valid;
  logic                    q_pop_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q.b0    <= spbd_pkg::CoefB0Reset;
      coefs_q.b1    <= '0;
      coefs_q.b2    <= '0;
      coefs_q.a1    <= '0;
      coefs_q.a2    <= '0;
      drive_q.gain  <= spbd_pkg::DriveGainReset;
      drive_q.recip <= spbd_pkg::DriveRecipReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (spbd_pkg::cfg_reg_e'(cfg_index_i))
        spbd_pkg::REG_B0:    coefs_q.b0    <= cfg_data_i;
        spbd_pkg::REG_B1:    coefs_q.b1    <= cfg_data_i;
        spbd_pkg::REG_B2:    coefs_q.b2    <= cfg_data_i;
        spbd_pkg::REG_A1:    coefs_q.a1    <= cfg_data_i;
        spbd_pkg::REG_A2:    coefs_q.a2    <= cfg_data_i;
        spbd_pkg::REG_GAIN:  drive_q.gain  <= cfg_data_i[spbd_pkg::DriveBits-1:0];
        spbd_pkg::REG_RECIP: drive_q.recip <= cfg_data_i[spbd_pkg::DriveBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame.last = s_axis_tlast;
    for (int ch = 0; ch < spbd_pkg::Channels; ch++) begin
      in_frame.x[ch] = s_axis_tdata[ch*SampleBits +: SampleBits];
    end
  end

  always_comb begin
    m_axis_tlast = out_frame.last;
    for (int ch = 0; ch < spbd_pkg::Channels; ch++) begin
      m_axis_tdata[ch*SampleBits +: SampleBits] = out_frame.x[ch];
    end
  end

  spbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_frame_i   (in_frame),
    .drive_i      (drive_q),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_frame_o (q_in_frame)
  );

  spbd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_frame_i (q_in_frame),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_frame_o  (q_out_frame)
  );

  spbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_frame_i (q_out_frame),
    .coefs_i     (coefs_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_frame_o (out_frame)
  );

endmodule

`default_nettype wire

@@ src/spbd_fifo.sv @@
// ----------------------------------------------------------------------------
// spbd_fifo: small frame queue
// Decouples the drive front end from the biquad back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spbd_fifo #(
  parameter int unsigned Depth = spbd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  spbd_pkg::frame_t push_frame_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output spbd_pkg::frame_t pop_frame_o
);

  localparam int PtrBits   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountBits = $clog2(Depth + 1);

  spbd_pkg::frame_t     mem_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q;
  logic [PtrBits-1:0]   rd_ptr_q;
  logic [CountBits-1:0] count_q;
  logic                 push;
  logic                 pop;

  assign push_ready_o = count_q < CountBits'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_frame_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(Depth))
    else $error("queue count above depth");

  a_push_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");
`endif

endmodule

`default_nettype wire

@@ src/spbd_front.sv @@
// ----------------------------------------------------------------------------
// spbd_front: input side, drive stage
// Takes a frame, applies gain, interpolated tanh and reciprocal gain in both
// lanes (bypassed when gain <= unity), then pushes the frame to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spbd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spbd_pkg::frame_t     in_frame_i,
  input  spbd_pkg::drive_cfg_t drive_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output spbd_pkg::frame_t     push_frame_o
);

  localparam int SampleBits   = spbd_pkg::SampleBits;
  localparam int DriveBits    = spbd_pkg::DriveBits;
  localparam int DrivenBits   = spbd_pkg::DrivenBits;
  localparam int FracBits     = spbd_pkg::TanhFracBits;
  localparam int AddrBits     = spbd_pkg::TabAddrBits;
  localparam int Depth        = spbd_pkg::TanhDepth;
  localparam int DrvProdBits  = SampleBits + DriveBits + 1;
  localparam int PosBits      = DrivenBits + AddrBits;
  localparam int IdxBits      = PosBits - FracBits;
  localparam int StepBits     = SampleBits + FracBits;
  localparam int TanhBits     = SampleBits + 1;
  localparam int ScBits       = TanhBits + DriveBits + 1;
  localparam int ScShBits     = ScBits - spbd_pkg::RecipFrac;

  typedef enum logic [5:0] {
    F_IDLE   = 6'b000001,
    F_MUL    = 6'b000010,
    F_LOOK   = 6'b000100,
    F_INTERP = 6'b001000,
    F_SCALE  = 6'b010000,
    F_PUSH   = 6'b100000
  } front_state_e;

  front_state_e state_q;
  front_state_e state_d;
  logic         accept;
  logic         last_q;
  logic         bypass_q;

  spbd_pkg::sample_t     y_lane [spbd_pkg::Channels];
  logic [SampleBits-1:0] tanh_rom [spbd_pkg::Channels][Depth + 1];

  // one copy of the table per lane, filled from constants
  for (genvar g = 0; g <= Depth; g++) begin : g_rom
    localparam logic [SampleBits-1:0] Entry = spbd_pkg::tanh_entry(g);
    for (genvar c = 0; c < spbd_pkg::Channels; c++) begin : g_copy
      assign tanh_rom[c][g] = Entry;
    end
  end

  assign in_ready_o   = state_q == F_IDLE;
  assign push_valid_o = state_q == F_PUSH;
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:   if (in_valid_i) state_d = F_MUL;
      F_MUL:    state_d = F_LOOK;
      F_LOOK:   state_d = F_INTERP;
      F_INTERP: state_d = F_SCALE;
      F_SCALE:  state_d = F_PUSH;
      F_PUSH:   if (push_ready_i) state_d = F_IDLE;
      default:  state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q   <= in_frame_i.last;
      bypass_q <= drive_i.gain <= spbd_pkg::DriveOne;
    end
  end

  // Each lane runs freely off x_q, which only changes on accept, so every
  // stage register is valid in the state after the one that computes it.
  for (genvar ch = 0; ch < spbd_pkg::Channels; ch++) begin : g_lane
    spbd_pkg::sample_t        x_q;
    logic signed [DrvProdBits-1:0] drv_prod;
    logic signed [DrivenBits-1:0]  driven_q;
    logic [DrivenBits-1:0]    mag;
    logic [PosBits-1:0]       pos;
    logic [IdxBits-1:0]       idx;
    logic                     over;
    logic [AddrBits-1:0]      addr_lo;
    logic [AddrBits-1:0]      addr_hi;
    logic [SampleBits-1:0]    tab_lo_q;
    logic [SampleBits-1:0]    tab_hi_q;
    logic [FracBits-1:0]      frac_q;
    logic                     neg_q;
    logic                     over_q;
    logic [SampleBits-1:0]    diff;
    logic [StepBits-1:0]      step_prod;
    logic [SampleBits-1:0]    mag_t;
    logic signed [TanhBits-1:0] t_q;
    logic signed [ScBits-1:0]   sc_prod;
    spbd_pkg::sample_t        y_q;

    assign drv_prod = x_q * $signed({1'b0, drive_i.gain});

    assign mag     = driven_q[DrivenBits-1] ? DrivenBits'(-driven_q) : driven_q;
    assign pos     = {{AddrBits{1'b0}}, mag} * PosBits'(Depth);
    assign idx     = pos[PosBits-1:FracBits];
    assign over    = idx >= IdxBits'(Depth);
    assign addr_lo = over ? '0 : idx[AddrBits-1:0];
    assign addr_hi = addr_lo + 1'b1;

    assign diff      = (tab_hi_q > tab_lo_q) ? tab_hi_q - tab_lo_q : '0;
    assign step_prod = {{FracBits{1'b0}}, diff} * {{SampleBits{1'b0}}, frac_q};
    assign mag_t     = over_q ? spbd_pkg::SampleMaxU
                              : tab_lo_q + step_prod[FracBits +: SampleBits];

    assign sc_prod = t_q * $signed({1'b0, drive_i.recip});

    always_ff @(posedge clk_i) begin
      if (accept) begin
        x_q <= in_frame_i.x[ch];
      end
      driven_q <= drv_prod[spbd_pkg::DriveFrac +: DrivenBits];
      tab_lo_q <= tanh_rom[ch][addr_lo];
      tab_hi_q <= tanh_rom[ch][addr_hi];
      frac_q   <= pos[FracBits-1:0];
      neg_q    <= driven_q[DrivenBits-1];
      over_q   <= over;
      t_q      <= neg_q ? -$signed({1'b0, mag_t}) : $signed({1'b0, mag_t});
      y_q      <= bypass_q ? x_q
                : spbd_pkg::sat_sample(32'($signed(sc_prod[ScBits-1:spbd_pkg::RecipFrac])));
    end

    assign y_lane[ch] = y_q;
  end

  always_comb begin
    push_frame_o.last = last_q;
    for (int ch = 0; ch < spbd_pkg::Channels; ch++) begin
      push_frame_o.x[ch] = y_lane[ch];
    end
  end

endmodule

`default_nettype wire

@@ src/spbd_back.sv @@
// ----------------------------------------------------------------------------
// spbd_back: direct-form-I biquad per lane
// One multiplier per lane walks the five taps, then rounds, saturates,
// updates the history and loads the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spbd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  output logic                    pop_ready_o,
  input  spbd_pkg::frame_t        pop_frame_i,
  input  spbd_pkg::biquad_coefs_t coefs_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output spbd_pkg::frame_t        out_frame_o
);

  localparam int SampleBits = spbd_pkg::SampleBits;
  localparam int CoefBits   = spbd_pkg::CoefBits;
  localparam int FracBits   = spbd_pkg::CoefFracBits;
  localparam int OpBits     = CoefBits + 1;
  localparam int ProdBits   = OpBits + SampleBits;
  localparam int AccBits    = ProdBits + 3;
  localparam logic signed [AccBits-1:0] RoundHalf = AccBits'(1) << (FracBits - 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MAC  = 4'b0010,
    B_ACC  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_e;

  typedef enum logic [2:0] {
    TAP_B0 = 3'd0,
    TAP_B1 = 3'd1,
    TAP_B2 = 3'd2,
    TAP_A1 = 3'd3,
    TAP_A2 = 3'd4
  } tap_e;

  back_state_e      state_q;
  back_state_e      state_d;
  tap_e             cnt_q;
  logic             take;
  logic             out_free;
  logic             commit;
  logic             add_en;
  logic             last_q;
  logic             out_valid_q;
  spbd_pkg::frame_t out_frame_q;

  spbd_pkg::sample_t y_lane [spbd_pkg::Channels];

  assign pop_ready_o = state_q == B_IDLE;
  assign take        = pop_valid_i && pop_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign commit      = (state_q == B_OUT) && out_free;
  // the b0 product is registered and lands in the next cycle, so add nothing while cnt_q is TAP_B0
  assign add_en      = ((state_q == B_MAC) && (cnt_q != TAP_B0)) || (state_q == B_ACC);
  assign out_valid_o = out_valid_q;
  assign out_frame_o = out_frame_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (pop_valid_i) state_d = B_MAC;
      B_MAC:   if (cnt_q == TAP_A2) state_d = B_ACC;
      B_ACC:   state_d = B_OUT;
      B_OUT:   if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= TAP_B0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        cnt_q <= TAP_B0;
      end else if ((state_q == B_MAC) && (cnt_q != TAP_A2)) begin
        cnt_q <= tap_e'(cnt_q + 1'b1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      last_q <= pop_frame_i.last;
    end
    if (commit) begin
      out_frame_q.last <= last_q;
      for (int ch = 0; ch < spbd_pkg::Channels; ch++) begin
        out_frame_q.x[ch] <= y_lane[ch];
      end
    end
  end

  for (genvar ch = 0; ch < spbd_pkg::Channels; ch++) begin : g_lane
    spbd_pkg::sample_t          x_q;
    spbd_pkg::sample_t          x1_q;
    spbd_pkg::sample_t          x2_q;
    spbd_pkg::sample_t          y1_q;
    spbd_pkg::sample_t          y2_q;
    logic signed [OpBits-1:0]   c_op;
    spbd_pkg::sample_t          s_op;
    logic signed [ProdBits-1:0] prod_d;
    logic signed [ProdBits-1:0] prod_q;
    logic signed [AccBits-1:0]  acc_q;

    // feedback taps enter with the coefficient negated
    always_comb begin
      case (cnt_q)
        TAP_B0: begin
          c_op = {coefs_i.b0[CoefBits-1], coefs_i.b0};
          s_op = x_q;
        end
        TAP_B1: begin
          c_op = {coefs_i.b1[CoefBits-1], coefs_i.b1};
          s_op = x1_q;
        end
        TAP_B2: begin
          c_op = {coefs_i.b2[CoefBits-1], coefs_i.b2};
          s_op = x2_q;
        end
        TAP_A1: begin
          c_op = -$signed({coefs_i.a1[CoefBits-1], coefs_i.a1});
          s_op = y1_q;
        end
        TAP_A2: begin
          c_op = -$signed({coefs_i.a2[CoefBits-1], coefs_i.a2});
          s_op = y2_q;
        end
        default: begin
          c_op = '0;
          s_op = '0;
        end
      endcase
    end

    assign prod_d = c_op * s_op;
    assign y_lane[ch] =
      spbd_pkg::sat_sample(32'($signed(acc_q[AccBits-1:FracBits])));

    always_ff @(posedge clk_i) begin
      if (take) begin
        x_q <= pop_frame_i.x[ch];
      end
      prod_q <= prod_d;
      if (take) begin
        acc_q <= RoundHalf;
      end else if (add_en) begin
        acc_q <= acc_q + AccBits'(prod_q);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        x1_q <= '0;
        x2_q <= '0;
        y1_q <= '0;
        y2_q <= '0;
      end else if (commit) begin
        x1_q <= x_q;
        x2_q <= x1_q;
        y1_q <= y_lane[ch];
        y2_q <= y1_q;
      end
    end
  end

`ifndef ASSERT_OFF
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("computed frame not presented at output");
`endif

endmodule

`default_nettype wire
